FILE: src/first_unique_symbol_tracker_macros.svh
// ----------------------------------------------------------------------------
// First unique symbol tracker: assertion macros
// Shared property forms for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef FIRST_UNIQUE_SYMBOL_TRACKER_MACROS_SVH
`define FIRST_UNIQUE_SYMBOL_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FUST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define FUST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition that must hold in the cycle after reset is seen.
`define FUST_ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/fust_pkg.sv
// ----------------------------------------------------------------------------
// First unique symbol tracker: package
// Widths, status codes, alphabet limits and memory write request types.
// ----------------------------------------------------------------------------
package fust_pkg;

  localparam int SYM_W         = 8;
  localparam int SYM_COUNT     = 1 << SYM_W;
  localparam int ALPHABET_SIZE = 256;
  localparam int ALPHA_EFF     = (ALPHABET_SIZE < SYM_COUNT) ? ALPHABET_SIZE : SYM_COUNT;
  localparam int CNT_W         = SYM_W + 1;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [1:0]       status_t;

  localparam logic [SYM_W:0] ALPHA_LIMIT = (SYM_W + 1)'(ALPHA_EFF);
  localparam sym_t           MARK_NONE   = SYM_W'(35);

  localparam status_t ST_UNSEEN   = 2'd0;
  localparam status_t ST_ONCE     = 2'd1;
  localparam status_t ST_REPEATED = 2'd2;

  // Node entry: status of the symbol and its predecessor in the order list.
  typedef struct packed {
    status_t status;
    sym_t    prev;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic  en;
    sym_t  addr;
    node_t data;
  } node_wr_t;

  typedef struct packed {
    logic en;
    sym_t addr;
    sym_t data;
  } next_wr_t;

endpackage

FILE: src/fust_ram.sv
// ----------------------------------------------------------------------------
// First unique symbol tracker: generic RAM
// One write port, one read port, registered read data, read-first.
// ----------------------------------------------------------------------------
module fust_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/fust_fwd.sv
// ----------------------------------------------------------------------------
// First unique symbol tracker: read forwarding
// Capture a write that lands in the same cycle as a read to the same entry.
// ----------------------------------------------------------------------------
module fust_fwd import fust_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     rd_en,
  input  sym_t     rd_addr,
  input  node_wr_t node_wr,
  input  next_wr_t next_wr,
  input  node_t    node_q,
  input  sym_t     next_q,
  output node_t    node_data,
  output sym_t     next_data
);

  logic  node_hit;
  logic  next_hit;
  node_t node_fwd;
  sym_t  next_fwd;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_hit <= 1'b0;
      next_hit <= 1'b0;
    end else if (rd_en) begin
      node_hit <= node_wr.en && (node_wr.addr == rd_addr);
      next_hit <= next_wr.en && (next_wr.addr == rd_addr);
    end
    if (rd_en) begin
      node_fwd <= node_wr.data;
      next_fwd <= next_wr.data;
    end
  end

  assign node_data = node_hit ? node_fwd : node_q;
  assign next_data = next_hit ? next_fwd : next_q;

endmodule

FILE: src/fust_update.sv
// ----------------------------------------------------------------------------
// First unique symbol tracker: list update
// Decide append or unlink, hold head, tail, count and seen bits, issue writes.
// ----------------------------------------------------------------------------
module fust_update import fust_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  sym_t     sym,
  input  logic     start,
  input  node_t    node_data,
  input  sym_t     next_data,
  output node_wr_t node_wr,
  output next_wr_t next_wr,
  output logic     split,
  output sym_t     res_sym,
  output logic     res_found
);

  logic [SYM_COUNT-1:0] seen;
  logic [SYM_COUNT-1:0] seen_next;
  sym_t     head;
  sym_t     head_next;
  sym_t     tail;
  sym_t     tail_next;
  cnt_t     count;
  cnt_t     count_next;
  logic     c_pend;
  sym_t     c_addr;
  sym_t     c_prev;
  sym_t     head_cur;
  sym_t     tail_cur;
  cnt_t     count_cur;
  status_t  status;
  logic     in_range;
  logic     do_append;
  logic     do_unlink;
  node_wr_t node_w;
  next_wr_t next_w;

  always_comb begin
    head_cur  = start ? '0 : head;
    tail_cur  = start ? '0 : tail;
    count_cur = start ? '0 : count;
    in_range  = {1'b0, sym} < ALPHA_LIMIT;
    status    = ST_UNSEEN;
    if (!start && seen[sym]) begin
      status = node_data.status;
    end
    do_append  = in_range && (status == ST_UNSEEN);
    do_unlink  = in_range && (status == ST_ONCE);
    head_next  = head_cur;
    tail_next  = tail_cur;
    count_next = count_cur;
    seen_next  = start ? '0 : seen;
    node_w     = '{en: 1'b0, addr: sym, data: '{status: ST_ONCE, prev: tail_cur}};
    next_w     = '{en: 1'b0, addr: tail_cur, data: sym};
    split      = 1'b0;
    if (do_append) begin
      node_w.en      = 1'b1;
      seen_next[sym] = 1'b1;
      if (count_cur == '0) begin
        head_next = sym;
      end else begin
        next_w.en = 1'b1;
      end
      tail_next  = sym;
      count_next = count_cur + CNT_W'(1);
    end else if (do_unlink) begin
      node_w.en   = 1'b1;
      node_w.data = '{status: ST_REPEATED, prev: node_data.prev};
      if (count_cur == CNT_W'(1)) begin
        count_next = '0;
      end else if (count_cur != '0) begin
        count_next = count_cur - CNT_W'(1);
        if (sym == head_cur) begin
          head_next = next_data;
        end else if (sym == tail_cur) begin
          tail_next = node_data.prev;
        end else begin
          // middle element: bypass forward here, back link in the next cycle
          next_w = '{en: 1'b1, addr: node_data.prev, data: next_data};
          split  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (c_pend) begin
      node_wr = '{en: 1'b1, addr: c_addr, data: '{status: ST_ONCE, prev: c_prev}};
    end else begin
      node_wr    = node_w;
      node_wr.en = fire && node_w.en;
    end
    next_wr    = next_w;
    next_wr.en = fire && next_w.en;
  end

  assign res_found = count_next != '0;
  assign res_sym   = res_found ? head_next : MARK_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= '0;
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      c_pend <= 1'b0;
    end else begin
      c_pend <= fire && split;
      if (fire) begin
        seen  <= seen_next;
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
    if (fire && split) begin
      c_addr <= next_data;
      c_prev <= node_data.prev;
    end
  end

endmodule

FILE: src/first_unique_symbol_tracker.sv
// ----------------------------------------------------------------------------
// First unique symbol tracker: top level
// Reports the earliest symbol of the stream seen exactly once, per word.
// ----------------------------------------------------------------------------
// Data path: update stage register, then output register for the result word.
// Throughput: one word per cycle while the output is not stalled; a symbol
//   whose second sighting unlinks a middle list element stalls the input,
//   as the single node memory port writes status and successor back link.
// Reset: clears head, tail, count, seen bits and both pipeline valids; the
//   link memories keep their contents and need no clearing pass.
module first_unique_symbol_tracker import fust_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [SYM_W-1:0] symbol,
  input  logic             stream_start,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SYM_W-1:0] first_unique,
  output logic             found
);

  // Pipeline: the accept cycle reads the node and next memories at the
  // symbol; the update stage then decides append or unlink from the read
  // data, writes the memories back and loads the output register.
  logic     in_accept;
  logic     b_valid;
  sym_t     b_sym;
  logic     b_start;
  logic     out_free;
  logic     b_fire;
  logic     split;
  node_wr_t node_wr;
  next_wr_t next_wr;
  logic [NODE_W-1:0] node_q_raw;
  node_t    node_q;
  sym_t     next_q;
  node_t    node_data;
  sym_t     next_data;
  sym_t     res_sym;
  logic     res_found;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign b_fire    = b_valid && out_free;

  // Hold the input while the update stage is blocked, and in the cycle in which
  // a middle unlink writes its first half, so the next read meets the second.
  assign in_stall = b_valid && (!out_free || split);

  // Update stage register: hold the word until its result can be loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_accept) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
    if (in_accept) begin
      b_sym   <= symbol;
      b_start <= stream_start;
    end
  end

  // Node memory: status and predecessor per symbol.
  fust_ram #(
    .WIDTH (NODE_W),
    .DEPTH (SYM_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (node_wr.en),
    .wr_addr (node_wr.addr),
    .wr_data (node_wr.data),
    .rd_en   (in_accept),
    .rd_addr (symbol),
    .rd_data (node_q_raw)
  );

  assign node_q = node_t'(node_q_raw);

  // Next memory: successor per symbol.
  fust_ram #(
    .WIDTH (SYM_W),
    .DEPTH (SYM_COUNT)
  ) u_next_ram (
    .clk     (clk),
    .wr_en   (next_wr.en),
    .wr_addr (next_wr.addr),
    .wr_data (next_wr.data),
    .rd_en   (in_accept),
    .rd_addr (symbol),
    .rd_data (next_q)
  );

  // Patch read data with any write that landed in the read cycle.
  fust_fwd u_fwd (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_accept),
    .rd_addr   (symbol),
    .node_wr   (node_wr),
    .next_wr   (next_wr),
    .node_q    (node_q),
    .next_q    (next_q),
    .node_data (node_data),
    .next_data (next_data)
  );

  fust_update u_update (
    .clk       (clk),
    .rst       (rst),
    .fire      (b_fire),
    .sym       (b_sym),
    .start     (b_start),
    .node_data (node_data),
    .next_data (next_data),
    .node_wr   (node_wr),
    .next_wr   (next_wr),
    .split     (split),
    .res_sym   (res_sym),
    .res_found (res_found)
  );

  // Output register: decouple the result word from the update stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (b_fire) begin
      first_unique <= res_sym;
      found        <= res_found;
    end
  end

endmodule

FILE: src/fust_checker.sv
// ----------------------------------------------------------------------------
// First unique symbol tracker: port checker
// Watch word counts, idle acceptance, the empty mark, output hold and reset.
// ----------------------------------------------------------------------------
`include "first_unique_symbol_tracker_macros.svh"

module fust_checker import fust_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [SYM_W-1:0] first_unique,
  input logic             found
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] inflight;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Track words taken but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 2'd0;
    end else begin
      inflight <= inflight + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `FUST_ASSERT_IMPLY(a_no_spurious_word, clk, rst, out_acc, inflight != 2'd0)
  `FUST_ASSERT_IMPLY(a_idle_takes_word, clk, rst, inflight == 2'd0, !in_stall)
  `FUST_ASSERT_IMPLY(a_empty_mark, clk, rst, out_valid && !found, first_unique == MARK_NONE)
  `FUST_ASSERT_NEXT(a_stalled_word_holds, clk, rst, out_valid && out_stall, out_valid && $stable(first_unique) && $stable(found))
  `FUST_ASSERT_AFTER_RESET(a_reset_empties_output, clk, rst, !out_valid)

endmodule

bind first_unique_symbol_tracker fust_checker u_fust_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .first_unique (first_unique),
  .found        (found)
);
